FILE: src/sacrf_pkg.sv
// ----------------------------------------------------------------------------
// sacrf_pkg: shared types and constants
// Geometry of the set-associative read cache and the request beat format.
// ----------------------------------------------------------------------------
package sacrf_pkg;
	localparam int ADDR_BITS    = 12;
	localparam int OFFSET_WIDTH = 4;
	localparam int SET_BITS     = 2;
	localparam int WAYS         = 4;
	localparam int AGE_BITS     = 16;

	localparam int TAG_BITS    = ADDR_BITS - OFFSET_WIDTH - SET_BITS;
	localparam int SET_COUNT   = 1 << SET_BITS;
	localparam int LINE_COUNT  = SET_COUNT * WAYS;
	localparam int WAY_BITS    = $clog2(WAYS);
	localparam int LINE_BITS   = SET_BITS + WAY_BITS;
	localparam int BYTE_BITS   = LINE_BITS + OFFSET_WIDTH;
	localparam int QDEPTH      = 2;

	localparam logic MODE_STORE = 1'b0;
	localparam logic MODE_READ  = 1'b1;

	typedef struct packed {
		logic                 mode;
		logic [ADDR_BITS-1:0] address;
		logic [7:0]           write_data;
	} req_t;

	typedef struct packed {
		logic [7:0]          read_data;
		logic                hit;
		logic [WAY_BITS-1:0] way_used;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SCAN,
		ST_FILL,
		ST_FREAD,
		ST_EMIT
	} back_state_t;
endpackage

FILE: src/sacrf_front.sv
// ----------------------------------------------------------------------------
// sacrf_front: request queue
// Small queue that accepts request beats and hands them to the back end.
// ----------------------------------------------------------------------------
module sacrf_front import sacrf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  req_t push_req,
	output logic req_valid,
	input  logic req_take,
	output req_t req
);
	req_t         slot_q [QDEPTH];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;

	assign full      = (cnt_q == 2'(QDEPTH));
	assign req_valid = (cnt_q != 2'd0);
	assign req       = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wr_q <= ~wr_q;
			if (req_take && req_valid) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(req_take && req_valid);
		end
	end
endmodule

FILE: src/sacrf_back.sv
// ----------------------------------------------------------------------------
// sacrf_back: cache engine
// Stores bytes, looks up tags, picks a victim way and fills lines.
// ----------------------------------------------------------------------------
module sacrf_back import sacrf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_take,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_take,
	output rsp_t rsp
);
	logic [7:0]          store_mem [1 << ADDR_BITS];
	logic [7:0]          line_mem  [1 << BYTE_BITS];
	logic [TAG_BITS-1:0] tag_q     [LINE_COUNT];
	logic                valid_q   [LINE_COUNT];
	logic [AGE_BITS-1:0] age_q     [LINE_COUNT];

	back_state_t         state_q, state_d;
	req_t                cur_q;
	logic [WAY_BITS-1:0] way_q;
	logic [OFFSET_WIDTH:0] idx_q;
	logic [7:0]          srd_q;
	logic [7:0]          lrd_q;
	logic                hit_q;
	rsp_t                out_q;
	logic                outv_q;

	logic [SET_BITS-1:0]     set_w;
	logic [TAG_BITS-1:0]     tag_w;
	logic [OFFSET_WIDTH-1:0] off_w;
	logic                    hit_w;
	logic [WAY_BITS-1:0]     hway_w;
	logic                    inv_w;
	logic [WAY_BITS-1:0]     vway_w;
	logic [AGE_BITS-1:0]     best_w;
	logic [AGE_BITS-1:0]     raised_w [WAYS];

	assign off_w = cur_q.address[OFFSET_WIDTH-1:0];
	assign set_w = cur_q.address[OFFSET_WIDTH +: SET_BITS];
	assign tag_w = cur_q.address[ADDR_BITS-1 -: TAG_BITS];

	// Tag compare and victim choice over the ways of one set.
	always_comb begin
		hit_w  = 1'b0;
		hway_w = '0;
		inv_w  = 1'b0;
		vway_w = '0;
		best_w = '0;
		for (int w = 0; w < WAYS; w++) begin
			raised_w[w] = (&age_q[{set_w, WAY_BITS'(w)}]) ? age_q[{set_w, WAY_BITS'(w)}]
				: age_q[{set_w, WAY_BITS'(w)}] + 1'b1;
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (valid_q[{set_w, WAY_BITS'(w)}] && tag_q[{set_w, WAY_BITS'(w)}] == tag_w) begin
				hit_w  = 1'b1;
				hway_w = WAY_BITS'(w);
			end
			if (!valid_q[{set_w, WAY_BITS'(w)}]) begin
				inv_w  = 1'b1;
				vway_w = WAY_BITS'(w);
			end
		end
		if (!inv_w) begin
			for (int w = 0; w < WAYS; w++) begin
				if (w == 0 || raised_w[w] > best_w) begin
					best_w = raised_w[w];
					vway_w = WAY_BITS'(w);
				end
			end
		end
	end

	assign rsp_valid = outv_q;
	assign rsp       = out_q;

	always_comb begin
		state_d  = state_q;
		req_take = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					req_take = 1'b1;
					state_d  = (req.mode == MODE_READ) ? ST_LOOK : ST_IDLE;
				end
			end
			// A hit still passes through the line read so the byte comes from the hit way.
			ST_LOOK:  state_d = hit_w ? ST_FREAD : ST_SCAN;
			ST_SCAN:  state_d = ST_FILL;
			ST_FILL:  state_d = idx_q[OFFSET_WIDTH] ? ST_FREAD : ST_FILL;
			ST_FREAD: state_d = ST_EMIT;
			ST_EMIT:  state_d = outv_q ? ST_EMIT : ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			cur_q <= req;
			if (req.mode == MODE_STORE) store_mem[req.address] <= req.write_data;
		end
		if (state_q == ST_LOOK) begin
			hit_q <= hit_w;
			way_q <= hit_w ? hway_w : vway_w;
		end
		// Backing store read runs one byte ahead of the line write.
		srd_q <= store_mem[{cur_q.address[ADDR_BITS-1:OFFSET_WIDTH], idx_q[OFFSET_WIDTH-1:0]}];
		if (state_q == ST_FILL && idx_q != '0) begin
			line_mem[{set_w, way_q, OFFSET_WIDTH'(idx_q - 1'b1)}] <= srd_q;
		end
		lrd_q <= line_mem[{set_w, way_q, off_w}];
		if (state_q == ST_SCAN) tag_q[{set_w, way_q}] <= tag_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			outv_q  <= 1'b0;
			out_q   <= '0;
			for (int i = 0; i < LINE_COUNT; i++) begin
				valid_q[i] <= 1'b0;
				age_q[i]   <= '0;
			end
		end else begin
			state_q <= state_d;
			if (rsp_take && outv_q) outv_q <= 1'b0;
			unique case (state_q)
				ST_LOOK: begin
					idx_q <= '0;
				end
				ST_SCAN: begin
					// Ways up to the first invalid one age; all age when the set is full.
					// The filled way restarts at age one.
					for (int w = 0; w < WAYS; w++) begin
						if (WAY_BITS'(w) == way_q) begin
							age_q[{set_w, WAY_BITS'(w)}] <= AGE_BITS'(1);
						end else if (!inv_w || WAY_BITS'(w) < way_q) begin
							age_q[{set_w, WAY_BITS'(w)}] <= raised_w[w];
						end
					end
					valid_q[{set_w, way_q}] <= 1'b1;
					idx_q <= idx_q + 1'b1;
				end
				ST_FILL: begin
					if (!idx_q[OFFSET_WIDTH]) idx_q <= idx_q + 1'b1;
				end
				ST_EMIT: begin
					if (!outv_q) begin
						outv_q <= 1'b1;
						out_q  <= '{read_data: lrd_q, hit: hit_q, way_used: way_q};
					end
				end
				default: ;
			endcase
		end
	end
endmodule

FILE: src/set_assoc_cache_read_fifo.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_read_fifo: read-only set-associative byte cache
// Queue-style request and result ports around a four-way cache engine.
// ----------------------------------------------------------------------------
// Push a beat with mode 0 to store a byte into the 4 KiB backing store (no
// result, the cache is not updated), or with mode 1 to read a byte through
// the four-way, four-set cache with 16-byte lines. Each read gives one
// result beat with the byte, a hit flag and the way that hit or was filled.
// A two-entry request queue decouples the inputs from the cache engine, and
// a one-beat result register decouples the engine from the reader. The engine
// works on one request at a time; a miss fills the line through the byte-wide
// backing store port, one byte a cycle.
module set_assoc_cache_read_fifo import sacrf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 mode,
	input  logic [ADDR_BITS-1:0] address,
	input  logic [7:0]           write_data,
	output logic                 empty,
	input  logic                 pop,
	output logic [7:0]           read_data,
	output logic                 hit,
	output logic [WAY_BITS-1:0]  way_used
);
	req_t push_req, req;
	logic req_valid, req_take, rsp_valid;
	rsp_t rsp;

	assign push_req = '{mode: mode, address: address, write_data: write_data};

	sacrf_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .push_req(push_req),
		.req_valid(req_valid), .req_take(req_take), .req(req)
	);

	sacrf_back u_back (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_take(req_take),
		.req(req), .rsp_valid(rsp_valid), .rsp_take(pop), .rsp(rsp)
	);

	assign empty     = !rsp_valid;
	assign read_data = rsp.read_data;
	assign hit       = rsp.hit;
	assign way_used  = rsp.way_used;
endmodule
